// ----- rtl/cvrp_pkg.sv -----
`timescale 1ns / 1ps
package cvrp_pkg;

  localparam int CORNER_COUNT = 8;
  localparam int CORNER_W     = 3;
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int ANGLE_W      = 16;
  localparam int COORD_W      = 16;
  localparam int SINE_W       = 16;
  localparam int TRIG_W       = 17;
  localparam int DIFF_W       = 18;
  localparam int PA_W         = 35;
  localparam int X_W          = 36;
  localparam int MX_W         = 48;
  localparam int MY_W         = 32;
  localparam int NUM_W        = 30;
  localparam int RECIP_W      = 32;
  localparam int RECIP_SHIFT  = 47;
  localparam int CR_SHIFT     = 15;
  localparam int X_SHIFT      = 31;
  localparam int Y_SHIFT      = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET   = 11'd64;
  localparam logic [ANGLE_W-1:0] ANGLE_WRAP  = 16'd36000;
  localparam logic [NUM_W-1:0]   ANGLE_HALF  = 30'd18000;
  localparam logic [63:0]        RECIP_WIDE  = ((64'd1 << RECIP_SHIFT) + 64'd35999) / 64'd36000;
  localparam logic [RECIP_W-1:0] PHASE_RECIP = RECIP_WIDE[RECIP_W-1:0];
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EDGE_LENGTH,
    REG_CENTER_COL,
    REG_CENTER_ROW
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROM_ROLL,
    S_ROM_PITCH,
    S_TRIG,
    S_SRMUL,
    S_CORNER,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                mul;
    logic                rom_pitch;
    logic                load_roll;
    logic                load_pitch;
    logic                mul_sr;
    logic                corner_valid;
    logic                corner_last;
    logic [CORNER_W-1:0] corner_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic drain_last;
  } dp_status_t;

  // quarter-wave sine entry, q30 series rounded to q15
  function automatic logic [SINE_W-1:0] series_sine(input logic [31:0] k,
                                                    input int unsigned bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = ({32'd0, k} * HALF_PI_Q30) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    rnd = ($unsigned(sum) + 64'd16384) >> 15;
    if (rnd > 64'd32768) begin
      rnd = 64'd32768;
    end
    return rnd[SINE_W-1:0];
  endfunction

endpackage

// ----- rtl/cvrp_sine_rom.sv -----
`timescale 1ns / 1ps
module cvrp_sine_rom #(
  parameter int TABLE_BITS = 10
) (
  input  logic                        clk,
  input  logic [TABLE_BITS:0]         addr_a,
  input  logic [TABLE_BITS:0]         addr_b,
  output logic [cvrp_pkg::SINE_W-1:0] data_a,
  output logic [cvrp_pkg::SINE_W-1:0] data_b
);
  import cvrp_pkg::*;

  localparam int DEPTH = (1 << TABLE_BITS) + 1;

  logic [SINE_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [SINE_W-1:0] VALUE = series_sine(32'(k), TABLE_BITS);
    assign rom[k] = VALUE;
  end

  always_ff @(posedge clk) begin
    data_a <= rom[addr_a];
    data_b <= rom[addr_b];
  end

endmodule

// ----- rtl/cvrp_datapath.sv -----
`timescale 1ns / 1ps
module cvrp_datapath #(
  parameter int TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [cvrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cvrp_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [cvrp_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [cvrp_pkg::ANGLE_W-1:0] pitch_angle,
  input  cvrp_pkg::dp_cmd_t                  cmd,
  output cvrp_pkg::dp_status_t               status,
  output logic                               result_valid,
  output logic [cvrp_pkg::CORNER_W-1:0]      corner_index,
  output logic signed [cvrp_pkg::COORD_W-1:0] screen_x,
  output logic signed [cvrp_pkg::COORD_W-1:0] screen_y,
  output logic                               last_corner
);
  import cvrp_pkg::*;

  localparam int QUARTER = 1 << TABLE_BITS;
  localparam int PHASE_W = TABLE_BITS + 2;
  localparam int ADDR_W  = TABLE_BITS + 1;
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam logic signed [MX_W-1:0] X_BIAS   = MX_W'((64'sd1 <<< X_SHIFT) - 64'sd1);
  localparam logic signed [MX_W-1:0] X_NOBIAS = '0;
  localparam logic signed [MY_W-1:0] Y_BIAS   = MY_W'((64'sd1 <<< Y_SHIFT) - 64'sd1);
  localparam logic signed [MY_W-1:0] Y_NOBIAS = '0;

  logic [CFG_W-1:0]  edge_length;
  logic [CFG_W-1:0]  center_col;
  logic [CFG_W-1:0]  center_row;
  logic [NUM_W-1:0]  roll_num;
  logic [NUM_W-1:0]  pitch_num;
  logic [PROD_W-1:0] roll_prod;
  logic [PROD_W-1:0] pitch_prod;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_cos;
  logic [ADDR_W-1:0]  addr_sin;
  logic [ADDR_W-1:0]  addr_cos;
  logic [SINE_W-1:0]  rom_sin;
  logic [SINE_W-1:0]  rom_cos;
  logic               neg_sin;
  logic               neg_cos;
  logic signed [TRIG_W-1:0] sin_val;
  logic signed [TRIG_W-1:0] cos_val;
  logic signed [TRIG_W-1:0] sin_roll;
  logic signed [TRIG_W-1:0] cos_roll;
  logic signed [DIFF_W-1:0] coef_a;
  logic signed [DIFF_W-1:0] coef_b;
  logic signed [PA_W-1:0]   prod_a;
  logic signed [PA_W-1:0]   prod_b;

  logic                     sel_sx;
  logic                     sel_sy;
  logic                     sel_sz;
  logic signed [X_W-1:0]    cr_term;
  logic signed [X_W-1:0]    z_sel;
  logic signed [X_W-1:0]    x_sel;
  logic signed [DIFF_W-1:0] y_sel;

  logic                     s1_valid;
  logic                     s1_last;
  logic [CORNER_W-1:0]      s1_idx;
  logic signed [X_W-1:0]    s1_x;
  logic signed [DIFF_W-1:0] s1_y;
  logic                     s2_valid;
  logic                     s2_last;
  logic [CORNER_W-1:0]      s2_idx;
  logic signed [MX_W-1:0]   s2_x;
  logic signed [MY_W-1:0]   s2_y;
  logic signed [MX_W-1:0]   x_biased;
  logic signed [MY_W-1:0]   y_biased;
  logic signed [CFG_W:0]    edge_q1;

  // wrap to 0..35999, scale to phase steps, add half a step for rounding
  function automatic logic [NUM_W-1:0] angle_num(input logic [ANGLE_W-1:0] angle);
    logic [ANGLE_W-1:0] m;
    m = angle + (angle[ANGLE_W-1] ? ANGLE_WRAP : '0);
    return (NUM_W'(m) << PHASE_W) + ANGLE_HALF;
  endfunction

  // mirror odd quadrants into the quarter table
  function automatic logic [ADDR_W-1:0] rom_addr(input logic [PHASE_W-1:0] p);
    logic [ADDR_W-1:0] k;
    k = {1'b0, p[TABLE_BITS-1:0]};
    return p[TABLE_BITS] ? ADDR_W'(QUARTER) - k : k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_length <= CFG_RESET;
      center_col  <= CFG_RESET;
      center_row  <= CFG_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_EDGE_LENGTH: edge_length <= cfg_data;
        REG_CENTER_COL:  center_col  <= cfg_data;
        REG_CENTER_ROW:  center_row  <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase = numerator / 36000 by reciprocal multiply, masked to a full turn
  always_comb begin
    phase     = cmd.rom_pitch ? pitch_prod[RECIP_SHIFT +: PHASE_W]
                              : roll_prod[RECIP_SHIFT +: PHASE_W];
    phase_cos = phase + PHASE_W'(QUARTER);
    addr_sin  = rom_addr(phase);
    addr_cos  = rom_addr(phase_cos);
  end

  cvrp_sine_rom #(
    .TABLE_BITS (TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .addr_a (addr_sin),
    .addr_b (addr_cos),
    .data_a (rom_sin),
    .data_b (rom_cos)
  );

  always_comb begin
    sin_val = neg_sin ? -$signed({1'b0, rom_sin}) : $signed({1'b0, rom_sin});
    cos_val = neg_cos ? -$signed({1'b0, rom_cos}) : $signed({1'b0, rom_cos});
  end

  always_ff @(posedge clk) begin
    neg_sin <= phase[PHASE_W-1];
    neg_cos <= phase_cos[PHASE_W-1];
    if (cmd.capture) begin
      roll_num  <= angle_num(roll_angle);
      pitch_num <= angle_num(pitch_angle);
    end
    if (cmd.mul) begin
      roll_prod  <= {{RECIP_W{1'b0}}, roll_num} * {{NUM_W{1'b0}}, PHASE_RECIP};
      pitch_prod <= {{RECIP_W{1'b0}}, pitch_num} * {{NUM_W{1'b0}}, PHASE_RECIP};
    end
    if (cmd.load_roll) begin
      sin_roll <= sin_val;
      cos_roll <= cos_val;
    end
    if (cmd.load_pitch) begin
      coef_a <= DIFF_W'(cos_val) - DIFF_W'(sin_val);
      coef_b <= DIFF_W'(cos_val) + DIFF_W'(sin_val);
    end
    if (cmd.mul_sr) begin
      prod_a <= PA_W'(coef_a) * PA_W'(sin_roll);
      prod_b <= PA_W'(coef_b) * PA_W'(sin_roll);
    end
  end

  // corner signs pick the rotated-term combination
  always_comb begin
    sel_sx  = cmd.corner_idx[0] ^ cmd.corner_idx[1];
    sel_sy  = cmd.corner_idx[1];
    sel_sz  = cmd.corner_idx[2];
    cr_term = X_W'(cos_roll) <<< CR_SHIFT;
    if (sel_sy == sel_sz) begin
      y_sel = sel_sy ? coef_a : -coef_a;
      z_sel = sel_sy ? X_W'(prod_b) : -X_W'(prod_b);
    end else begin
      y_sel = sel_sy ? coef_b : -coef_b;
      z_sel = sel_sz ? X_W'(prod_a) : -X_W'(prod_a);
    end
    x_sel = (sel_sx ? cr_term : -cr_term) + z_sel;
  end

  assign edge_q1 = $signed({1'b0, edge_length});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1_valid     <= cmd.corner_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last      <= cmd.corner_last;
    s1_idx       <= cmd.corner_idx;
    s1_x         <= x_sel;
    s1_y         <= y_sel;
    s2_last      <= s1_last;
    s2_idx       <= s1_idx;
    s2_x         <= MX_W'(s1_x) * MX_W'(edge_q1);
    s2_y         <= MY_W'(s1_y) * MY_W'(edge_q1);
    last_corner  <= s2_last;
    corner_index <= s2_idx;
    screen_x     <= x_biased[X_SHIFT +: COORD_W] + COORD_W'(center_col);
    screen_y     <= y_biased[Y_SHIFT +: COORD_W] + COORD_W'(center_row);
  end

  // truncate toward zero
  always_comb begin
    x_biased = s2_x + (s2_x[MX_W-1] ? X_BIAS : X_NOBIAS);
    y_biased = s2_y + (s2_y[MY_W-1] ? Y_BIAS : Y_NOBIAS);
  end

  assign status.drain_last = s2_valid & s2_last;

endmodule

// ----- rtl/cvrp_ctrl.sv -----
`timescale 1ns / 1ps
module cvrp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output cvrp_pkg::dp_cmd_t    cmd,
  input  cvrp_pkg::dp_status_t status
);
  import cvrp_pkg::*;

  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(CORNER_COUNT - 1);

  state_t              state;
  state_t              state_next;
  logic [CORNER_W-1:0] corner_cnt;
  logic [CORNER_W-1:0] corner_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      corner_cnt <= '0;
    end else begin
      state      <= state_next;
      corner_cnt <= corner_cnt_next;
    end
  end

  always_comb begin
    state_next      = state;
    corner_cnt_next = corner_cnt;
    cmd             = '0;
    cmd.corner_idx  = corner_cnt;
    busy            = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ROM_ROLL;
      end
      S_ROM_ROLL: begin
        state_next = S_ROM_PITCH;
      end
      S_ROM_PITCH: begin
        cmd.rom_pitch = 1'b1;
        cmd.load_roll = 1'b1;
        state_next    = S_TRIG;
      end
      S_TRIG: begin
        cmd.load_pitch = 1'b1;
        state_next     = S_SRMUL;
      end
      S_SRMUL: begin
        cmd.mul_sr      = 1'b1;
        corner_cnt_next = '0;
        state_next      = S_CORNER;
      end
      S_CORNER: begin
        cmd.corner_valid = 1'b1;
        cmd.corner_last  = (corner_cnt == LAST_CORNER);
        corner_cnt_next  = corner_cnt + 1'b1;
        if (corner_cnt == LAST_CORNER) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.drain_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/cube_vertex_rotate_project.sv -----
`timescale 1ns / 1ps
// channel   handshake               payload
// request   start / busy            roll_angle, pitch_angle
// result    result_valid strobe     corner_index, screen_x, screen_y, last_corner
// config    cfg_wr_en               cfg_index, cfg_data
//
// one request at a time, taken only while idle: phase multiply, sine rom reads for roll then pitch,
// a trig combine and a multiply, then eight corners through a three-stage pipe
// the first result follows the setup states and the s1, s2 and output registers, then one corner per cycle
// busy is high from the cycle after the request until the last corner leaves the pipe
// rst is synchronous; results cannot be stalled by the receiver
module cube_vertex_rotate_project #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cvrp_pkg::ANGLE_W-1:0] roll_angle,
  input  logic signed [cvrp_pkg::ANGLE_W-1:0] pitch_angle,
  input  logic                                cfg_wr_en,
  input  logic [cvrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cvrp_pkg::CFG_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic [cvrp_pkg::CORNER_W-1:0]       corner_index,
  output logic signed [cvrp_pkg::COORD_W-1:0] screen_x,
  output logic signed [cvrp_pkg::COORD_W-1:0] screen_y,
  output logic                                last_corner
);
  import cvrp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  cvrp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  cvrp_datapath #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .roll_angle   (roll_angle),
    .pitch_angle  (pitch_angle),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .corner_index (corner_index),
    .screen_x     (screen_x),
    .screen_y     (screen_y),
    .last_corner  (last_corner)
  );

`ifndef NO_ASSERTIONS
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in flight");

  a_last_is_final_corner: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_corner) |-> (corner_index == CORNER_W'(CORNER_COUNT - 1)))
    else $error("last_corner on wrong corner");

  a_corners_in_order: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_corner) |=>
      (result_valid && corner_index == $past(corner_index) + 1'b1))
    else $error("corner sequence broken");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but not busy");
`endif

endmodule
